FILE: rtl/spwm_pkg.sv
// Types and constants shared by the slow PWM block and its channel interfaces.
// Depends on nothing.
`default_nettype none

package spwm_pkg;

   localparam int PERIOD_W  = 16;
   localparam int DUTY_W    = 8;
   localparam int STAMP_W   = 32;
   localparam int QUOT_W    = 9;
   localparam int REM_W     = 8;
   localparam int DTIME_W   = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4000;
   localparam logic [DUTY_W-1:0]   DUTY_FULL    = 8'd255;
   localparam logic [15:0]         RECIP_255    = 16'h8081;
   localparam int                  RECIP_SHIFT  = 23;

   typedef enum logic {
      OP_UPDATE   = 1'b0,
      OP_SET_DUTY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quot;
      logic [REM_W-1:0]  rem;
   } period_split_type;

   // period = 255 * quot + rem
   function automatic period_split_type period_split(input logic [PERIOD_W-1:0] period);
      logic [31:0]       prod;
      logic [QUOT_W-1:0] quot;
      logic [16:0]       rem_wide;
      period_split_type  split;
      prod     = 32'(period) * 32'(RECIP_255);
      quot     = prod[RECIP_SHIFT +: QUOT_W];
      rem_wide = 17'(period) - 17'(17'(quot) * 17'(DUTY_FULL));
      split.quot = quot;
      split.rem  = rem_wide[REM_W-1:0];
      return split;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/spwm_req_if.sv
// Request channel of the slow PWM block: opcode, time stamp and duty.
// Depends on spwm_pkg.
`default_nettype none

interface spwm_req_if;
   logic                               valid;
   logic                               ready;
   spwm_pkg::opcode_type               opcode;
   logic [spwm_pkg::STAMP_W-1:0]       now_ms;
   logic [spwm_pkg::DUTY_W-1:0]        duty;

   modport source (output valid, output opcode, output now_ms, output duty, input ready);
   modport sink   (input valid, input opcode, input now_ms, input duty, output ready);
endinterface

`default_nettype wire

FILE: rtl/spwm_rsp_if.sv
// Response channel of the slow PWM block: drive level and duty in effect.
// Depends on spwm_pkg.
`default_nettype none

interface spwm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               output_on;
   logic [spwm_pkg::DUTY_W-1:0]        duty_now;

   modport source (output valid, output output_on, output duty_now, input ready);
   modport sink   (input valid, input output_on, input duty_now, output ready);
endinterface

`default_nettype wire

FILE: rtl/spwm_duty_calc.sv
// On time of one period: duty * period / 255, from the split period.
// Depends on spwm_pkg.
`default_nettype none

module spwm_duty_calc (
   input  logic [spwm_pkg::DUTY_W-1:0]  duty,
   input  spwm_pkg::period_split_type   split,
   output logic [spwm_pkg::DTIME_W-1:0] duty_time
);
   import spwm_pkg::*;

   logic [16:0] whole;
   logic [15:0] frac_prod;
   logic [16:0] frac_sum;
   logic [7:0]  frac;
   logic [16:0] total;

   // duty*period/255 = duty*quot + (duty*rem)/255, the latter below 2^16
   assign whole     = 17'(duty) * 17'(split.quot);
   assign frac_prod = 16'(duty) * 16'(split.rem);
   assign frac_sum  = 17'(frac_prod) + 17'(frac_prod[15:8]) + 17'd1;
   assign frac      = frac_sum[15:8];
   assign total     = whole + 17'(frac);
   assign duty_time = total[DTIME_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/slow_pwm_with_late_compensation.sv
// Slow time-proportioning PWM with lateness compensation, top level.
// Depends on spwm_pkg, spwm_req_if, spwm_rsp_if and spwm_duty_calc.
//
// Usage:
//   req_chan carries one transaction per time stamp: opcode update, or set duty
//   (load duty, clear lateness, start a period) followed by an update.
//   rsp_chan returns one transaction per request: drive level and duty in force.
//   csr_write_en/csr_write_data load the period in ms; write only while idle.
// Timing:
//   Request register, then the update logic into the response register.
//   The response register follows the request register. One transaction is
//   taken every cycle unless the response stalls, the lateness and drive
//   state closing in the update logic. Duty is multiplied in the request stage.
// Reset:
//   Period returns to 4000 ms, duty, lateness, period start and drive to zero;
//   both stages empty.
// Stall:
//   A stalled response holds; the request register fills and then req_chan
//   ready drops until the response is taken.
`default_nettype none

module slow_pwm_with_late_compensation #(
   parameter int TIME_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   spwm_req_if.sink                         req_chan,
   spwm_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_en,
   input  logic [spwm_pkg::PERIOD_W-1:0]    csr_write_data
);
   import spwm_pkg::*;

   logic [PERIOD_W-1:0]  period_ff;
   period_split_type     split_ff;
   logic [DUTY_W-1:0]    duty_level_ff, duty_level_in;
   logic [TIME_BITS-1:0] duty_late_ff, duty_late_in;
   logic [TIME_BITS-1:0] period_late_ff, period_late_in;
   logic [TIME_BITS-1:0] period_start_ff, period_start_in;
   logic                 drive_ff, drive_in;

   logic                 s1_valid_ff;
   opcode_type           s1_opcode_ff;
   logic [TIME_BITS-1:0] s1_now_ff;
   logic [DUTY_W-1:0]    s1_duty_ff;
   logic [DTIME_W-1:0]   s1_dtime_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_on_ff;
   logic [DUTY_W-1:0]    rsp_duty_ff;

   logic                 s1_adv;
   logic                 req_take;
   logic [DUTY_W-1:0]    duty_sel;
   logic [DTIME_W-1:0]   dtime;

   logic                 set_duty;
   logic [TIME_BITS-1:0] late_base, plate_base, start_base;
   logic [TIME_BITS-1:0] d_w, period_w, half_w, corr;
   logic [TIME_BITS-1:0] adj_d, adj_p, elapsed, late_mid;
   logic                 drive_mid;

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_take       = req_chan.valid && req_chan.ready;

   // use an incoming set-duty's own duty, else forward one still in the request register
   always_comb begin
      if (req_chan.opcode == OP_SET_DUTY) begin
         duty_sel = req_chan.duty;
      end else if (s1_valid_ff && s1_opcode_ff == OP_SET_DUTY) begin
         duty_sel = s1_duty_ff;
      end else begin
         duty_sel = duty_level_ff;
      end
   end

   spwm_duty_calc u_duty_calc (
      .duty      (duty_sel),
      .split     (split_ff),
      .duty_time (dtime)
   );

   always_comb begin
      set_duty   = (s1_opcode_ff == OP_SET_DUTY);
      late_base  = set_duty ? '0 : duty_late_ff;
      plate_base = set_duty ? '0 : period_late_ff;
      start_base = set_duty ? s1_now_ff : period_start_ff;
      duty_level_in = set_duty ? s1_duty_ff : duty_level_ff;

      d_w      = TIME_BITS'(s1_dtime_ff);
      period_w = TIME_BITS'(period_ff);
      half_w   = TIME_BITS'(period_ff >> 1);
      adj_d    = d_w - late_base;
      elapsed  = s1_now_ff - start_base;
      corr     = ($signed(half_w) >= $signed(plate_base)) ? plate_base : half_w;
      adj_p    = period_w - corr;

      drive_mid = drive_ff;
      late_mid  = late_base;
      if (drive_ff && $signed(elapsed) >= $signed(adj_d)) begin
         drive_mid = 1'b0;
         late_mid  = late_base + elapsed - d_w;
      end

      drive_in        = drive_mid;
      duty_late_in    = late_mid;
      period_late_in  = plate_base;
      period_start_in = start_base;
      if (!drive_mid && $signed(elapsed) >= $signed(adj_p)) begin
         if (adj_d[TIME_BITS-1]) begin
            duty_late_in = late_mid - d_w;
         end else begin
            drive_in = 1'b1;
         end
         period_late_in  = plate_base + elapsed - period_w;
         period_start_in = s1_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= PERIOD_RESET;
         split_ff        <= period_split(PERIOD_RESET);
         duty_level_ff   <= '0;
         duty_late_ff    <= '0;
         period_late_ff  <= '0;
         period_start_ff <= '0;
         drive_ff        <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_on_ff       <= 1'b0;
         rsp_duty_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            period_ff <= csr_write_data;
            split_ff  <= period_split(csr_write_data);
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            duty_level_ff   <= duty_level_in;
            duty_late_ff    <= duty_late_in;
            period_late_ff  <= period_late_in;
            period_start_ff <= period_start_in;
            drive_ff        <= drive_in;
            rsp_valid_ff    <= 1'b1;
            rsp_on_ff       <= drive_in;
            rsp_duty_ff     <= duty_level_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff <= req_chan.opcode;
         s1_now_ff    <= TIME_BITS'(req_chan.now_ms);
         s1_duty_ff   <= req_chan.duty;
         s1_dtime_ff  <= dtime;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.output_on = rsp_on_ff;
   assign rsp_chan.duty_now  = rsp_duty_ff;

`ifndef SYNTH
   a_rsp_tracks_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_on_ff == drive_ff && rsp_duty_ff == duty_level_ff)
      else $error("response register out of step with drive state");

   a_adv_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("processed transaction left no response");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(period_start_ff) && $stable(duty_late_ff)
                  && $stable(period_late_ff) && $stable(drive_ff))
      else $error("PWM state moved without a transaction");

   a_stalled_s1_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("request register dropped a waiting transaction");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for slow_pwm_with_late_compensation: drives time-stamp
// transactions and period writes, and checks every response against a predictor.
// Depends on spwm_pkg, spwm_req_if, spwm_rsp_if and the block itself.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import spwm_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 64;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_ITEMS   = 240;
   localparam int HOLD_PHASE    = 3;
   localparam int PAUSE_PHASE   = 4;

   typedef struct packed {
      logic                output_on;
      logic [DUTY_W-1:0]   duty_now;
   } drive_result_type;

   class drive_level_checker_type;
      bit [PERIOD_W-1:0]   period_ms;
      bit [DUTY_W-1:0]     duty_level;
      bit [STAMP_W-1:0]    duty_late;
      bit [STAMP_W-1:0]    period_late;
      bit [STAMP_W-1:0]    period_start;
      bit                  drive_on;
      drive_result_type    expected_levels[$];
      int                  errors;

      function new();
         period_ms    = PERIOD_RESET;
         duty_level   = '0;
         duty_late    = '0;
         period_late  = '0;
         period_start = '0;
         drive_on     = 1'b0;
         errors       = 0;
      endfunction

      function void set_period(bit [PERIOD_W-1:0] value);
         period_ms = value;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function void advance_pwm(bit [STAMP_W-1:0] now);
         bit [STAMP_W-1:0] on_time;
         bit [STAMP_W-1:0] adj_on;
         bit [STAMP_W-1:0] elapsed;
         bit [STAMP_W-1:0] half;
         bit [STAMP_W-1:0] corr;
         bit [STAMP_W-1:0] adj_period;
         on_time    = (32'(duty_level) * 32'(period_ms)) / 32'(DUTY_FULL);
         adj_on     = on_time - duty_late;
         elapsed    = now - period_start;
         half       = 32'(period_ms >> 1);
         corr       = ($signed(half) >= $signed(period_late)) ? period_late : half;
         adj_period = 32'(period_ms) - corr;
         if (drive_on && $signed(elapsed) >= $signed(adj_on)) begin
            drive_on  = 1'b0;
            duty_late = duty_late + elapsed - on_time;
         end
         if (!drive_on && $signed(elapsed) >= $signed(adj_period)) begin
            // skip the on phase when lateness has eaten the whole on time
            if (adj_on[STAMP_W-1])
               duty_late = duty_late - on_time;
            else
               drive_on = 1'b1;
            period_late  = period_late + elapsed - 32'(period_ms);
            period_start = now;
         end
      endfunction

      function void note_request(opcode_type op, bit [STAMP_W-1:0] now,
                                 bit [DUTY_W-1:0] duty);
         drive_result_type res;
         if (op == OP_SET_DUTY) begin
            duty_level   = duty;
            duty_late    = '0;
            period_late  = '0;
            period_start = now;
         end
         advance_pwm(now);
         res.output_on = drive_on;
         res.duty_now  = duty_level;
         expected_levels.push_back(res);
      endfunction

      function void check_response(logic output_on, logic [DUTY_W-1:0] duty_now);
         drive_result_type want;
         if (expected_levels.size() == 0) begin
            $display("%0t: unexpected response output_on=%0b duty_now=%0d",
                     $realtime, output_on, duty_now);
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         if (output_on !== want.output_on) begin
            $display("%0t: output_on mismatch, expected %0b actual %0b",
                     $realtime, want.output_on, output_on);
            errors++;
         end
         if (duty_now !== want.duty_now) begin
            $display("%0t: duty_now mismatch, expected %0d actual %0d",
                     $realtime, want.duty_now, duty_now);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_en;
   logic [PERIOD_W-1:0] csr_write_data;

   spwm_req_if req_chan();
   spwm_rsp_if rsp_chan();

   slow_pwm_with_late_compensation dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   drive_level_checker_type board = new();

   bit               idle_en = 1'b1;
   int               hold_asks = 0;
   int               hold_taken = 0;
   int               hold_left = 0;
   int               cycles = 0;
   bit [STAMP_W-1:0] stamp_ms = '0;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            board.note_request(req_chan.opcode, req_chan.now_ms, req_chan.duty);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_response(rsp_chan.output_on, rsp_chan.duty_now);
      end
   end

   // hold off on request, otherwise stall at random while idle_en is set
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_taken != hold_asks) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (idle_en && $urandom_range(0, 99) < 33) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input opcode_type op, input bit [STAMP_W-1:0] now,
                            input bit [DUTY_W-1:0] duty);
      while (idle_en && $urandom_range(0, 99) < 33) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.now_ms <= now;
      req_chan.duty   <= duty;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic await_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_period(input bit [PERIOD_W-1:0] value);
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      board.set_period(value);
   endtask

   task automatic run_phase(input bit [PERIOD_W-1:0] period, input int phase_id);
      int         r;
      int         pick;
      int         span;
      int         p;
      opcode_type op;
      bit [7:0]   duty;
      p = int'(period);
      write_period(period);
      send_item(OP_SET_DUTY, stamp_ms, 8'($urandom_range(0, 255)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (phase_id == HOLD_PHASE && i == PHASE_ITEMS / 2)
            hold_asks++;
         if (phase_id == PAUSE_PHASE && i == PHASE_ITEMS / 2)
            await_results();
         r    = $urandom_range(0, 99);
         pick = $urandom_range(0, 9);
         span = (pick < 7) ? p / 4 + 1 : (pick < 9) ? p + 2 : 3 * p + 3;
         op   = OP_UPDATE;
         duty = 8'($urandom_range(0, 255));
         if (r < 6) begin
            op   = OP_SET_DUTY;
            pick = $urandom_range(0, 9);
            if (pick == 0)
               duty = 8'd0;
            else if (pick == 1)
               duty = DUTY_FULL;
         end
         if (r < 92) begin
            stamp_ms += 32'($urandom_range(0, span));
         end else begin
            // noise: jump anywhere or step back in time
            op = opcode_type'($urandom_range(0, 1));
            if (r < 96)
               stamp_ms = $urandom();
            else
               stamp_ms -= 32'($urandom_range(0, span));
         end
         send_item(op, stamp_ms, duty);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      req_chan.valid  <= 1'b0;
      req_chan.opcode <= OP_UPDATE;
      req_chan.now_ms <= '0;
      req_chan.duty   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // period at its reset value: on phase end, period end, late periods,
      // a skipped on phase, time stamp wrap and backward steps
      send_item(OP_SET_DUTY, 32'd0, 8'd0);
      send_item(OP_UPDATE, 32'd4000, 8'd0);
      send_item(OP_UPDATE, 32'd4000, 8'hFF);
      send_item(OP_SET_DUTY, 32'd5000, 8'd255);
      send_item(OP_UPDATE, 32'd9000, 8'd0);
      send_item(OP_UPDATE, 32'd9001, 8'd0);
      send_item(OP_SET_DUTY, 32'd20000, 8'd128);
      send_item(OP_UPDATE, 32'd22007, 8'd0);
      send_item(OP_UPDATE, 32'd22010, 8'd0);
      send_item(OP_UPDATE, 32'd24000, 8'd0);
      send_item(OP_UPDATE, 32'd27000, 8'd0);
      send_item(OP_UPDATE, 32'd29100, 8'd0);
      send_item(OP_UPDATE, 32'd31000, 8'd0);
      send_item(OP_SET_DUTY, 32'd40000, 8'd1);
      send_item(OP_UPDATE, 32'd41000, 8'd0);
      send_item(OP_UPDATE, 32'd44000, 8'd0);
      send_item(OP_UPDATE, 32'd48000, 8'd0);
      send_item(OP_SET_DUTY, 32'hFFFF_F000, 8'd200);
      send_item(OP_UPDATE, 32'h0000_0100, 8'd0);
      send_item(OP_UPDATE, 32'h8000_0000, 8'd0);
      send_item(OP_UPDATE, 32'h7FFF_FFFF, 8'd0);
      send_item(OP_UPDATE, 32'hFFFF_FFFF, 8'd0);
      send_item(OP_SET_DUTY, 32'hFFFF_FFFF, 8'd255);
      send_item(OP_UPDATE, 32'h0000_0FA0, 8'd0);

      run_phase(16'd1, 0);
      idle_en = 1'b0;
      run_phase(16'd65535, 1);
      idle_en = 1'b1;
      run_phase(16'd0, 2);
      run_phase(16'd2, HOLD_PHASE);
      run_phase(16'd255, PAUSE_PHASE);
      run_phase(16'd256, 5);
      run_phase(16'($urandom_range(3, 600)), 6);
      stamp_ms = 32'hFFFF_0000;
      run_phase(16'($urandom_range(601, 65534)), 7);

      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
